// ===== rtl/lme_pkg.sv =====
// ----------------------------------------------------------------------------
// lme_pkg
// Shared types and constants of the linear model error metrics block.
// ----------------------------------------------------------------------------
package lme_pkg;

  localparam int unsigned NumLanes = 8;
  localparam int unsigned CfgIdxW  = $clog2(NumLanes);
  localparam int unsigned CoefW    = 32;
  localparam int unsigned OpndW    = 24;
  localparam int unsigned ProdW    = CoefW + OpndW + 1;
  localparam int unsigned SumW     = ProdW + $clog2(NumLanes);
  localparam int unsigned PredW    = 40;

  localparam int unsigned DivNumW  = 96;
  localparam int unsigned DivDenW  = 128;
  localparam int unsigned DivCntW  = 7;

  localparam int unsigned MulW     = 64;

  localparam logic [15:0] MaxSamples   = 16'd65535;
  localparam logic [6:0]  HitLimitLow  = 7'd5;
  localparam logic [6:0]  HitLimitMid  = 7'd10;
  localparam logic [6:0]  HitLimitHigh = 7'd15;
  localparam logic [6:0]  PctScale     = 7'd100;
  localparam logic [14:0] PctScaleQ8   = 15'd25600;

  localparam logic [15:0] R2One   = 16'd16384;
  localparam logic [15:0] R2Min   = 16'h8000;
  localparam logic [16:0] R2Limit = 17'd49152;

  localparam logic [DivCntW-1:0] IterPct   = 7'd56;
  localparam logic [DivCntW-1:0] IterSum48 = 7'd48;
  localparam logic [DivCntW-1:0] IterSum64 = 7'd64;
  localparam logic [DivCntW-1:0] IterHit   = 7'd31;
  localparam logic [DivCntW-1:0] IterR2    = 7'd94;

  typedef enum logic [CfgIdxW-1:0] {
    RegIntercept,
    RegSize,
    RegLocation,
    RegSecurity,
    RegGarage,
    RegFloor,
    RegRooms,
    RegYear
  } cfg_reg_e;

  typedef enum logic [4:0] {
    StIdle,
    StMerge,
    StErr,
    StTerm,
    StPct,
    StAcc,
    StMae,
    StMse,
    StRoot,
    StMape,
    StHitL,
    StHitM,
    StHitH,
    StMulA,
    StMulB,
    StMulC,
    StR2Div,
    StOut
  } st_e;

  typedef struct packed {
    logic [23:0] house_size;
    logic [7:0]  location_code;
    logic [7:0]  security_level;
    logic [7:0]  garage_count;
    logic [7:0]  floor_index;
    logic [7:0]  room_count;
    logic [11:0] built_year;
    logic [23:0] actual_price;
    logic        last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] predicted_price;
    logic               metrics_valid;
    logic [15:0]        samples_seen;
    logic [31:0]        mean_abs_error;
    logic [31:0]        root_mean_sq_error;
    logic [15:0]        mean_abs_pct_error;
    logic signed [15:0] r_squared;
    logic [14:0]        hit_pct_low;
    logic [14:0]        hit_pct_mid;
    logic [14:0]        hit_pct_high;
  } out_item_t;

endpackage

// ===== rtl/lme_stream_if.sv =====
// ----------------------------------------------------------------------------
// lme_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface lme_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lme_lane.sv =====
// ----------------------------------------------------------------------------
// lme_lane
// One product lane: signed coefficient times unsigned operand, registered.
// ----------------------------------------------------------------------------
module lme_lane (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [lme_pkg::CoefW-1:0]  coef_i,
  input  logic        [lme_pkg::OpndW-1:0]  opnd_i,
  output logic signed [lme_pkg::ProdW-1:0]  prod_o
);
  import lme_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= coef_i * $signed({1'b0, opnd_i});
    end
  end

  assign prod_o = prod_q;
endmodule

// ===== rtl/lme_merge.sv =====
// ----------------------------------------------------------------------------
// lme_merge
// Adds the lane products, rounds Q.24 to Q.8 and saturates the prediction.
// ----------------------------------------------------------------------------
module lme_merge (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [lme_pkg::ProdW-1:0]  prod_i [lme_pkg::NumLanes],
  output logic signed [lme_pkg::PredW-1:0]  pred_o
);
  import lme_pkg::*;

  localparam logic [SumW-1:0] RoundBias = SumW'(32768);

  logic signed [SumW-1:0]  sum_w;
  logic        [SumW-1:0]  rnd_w;
  logic signed [PredW-1:0] pred_d;
  logic signed [PredW-1:0] pred_q;

  always_comb begin
    sum_w = '0;
    for (int k = 0; k < NumLanes; k++) begin
      sum_w = sum_w + SumW'(prod_i[k]);
    end
    rnd_w = sum_w + RoundBias;
    // fits when the bits above the kept sign all match it
    if (&rnd_w[SumW-1:PredW+15] || ~|rnd_w[SumW-1:PredW+15]) begin
      pred_d = rnd_w[PredW+15:16];
    end else if (rnd_w[SumW-1]) begin
      pred_d = {1'b1, {(PredW-1){1'b0}}};
    end else begin
      pred_d = {1'b0, {(PredW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pred_q <= pred_d;
    end
  end

  assign pred_o = pred_q;
endmodule

// ===== rtl/lme_div.sv =====
// ----------------------------------------------------------------------------
// lme_div
// Restoring divider, one quotient bit per cycle. The numerator comes in
// aligned to the top so that iters_i steps cover all of its bits.
// ----------------------------------------------------------------------------
module lme_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [lme_pkg::DivNumW-1:0]       num_i,
  input  logic [lme_pkg::DivDenW-1:0]       den_i,
  input  logic [lme_pkg::DivCntW-1:0]       iters_i,
  output logic [lme_pkg::DivNumW-1:0]       quo_o,
  output logic                              done_o
);
  import lme_pkg::*;

  logic [DivNumW-1:0] quo_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DivDenW:0]   rem_sh;
  logic               ge;

  assign rem_sh = {rem_q, quo_q[DivNumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= DivDenW'(rem_sh - {1'b0, den_q});
        quo_q <= {quo_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DivDenW-1:0];
        quo_q <= {quo_q[DivNumW-2:0], 1'b0};
      end
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;
endmodule

// ===== rtl/lme_sqrt.sv =====
// ----------------------------------------------------------------------------
// lme_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module lme_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic [31:0] root_o,
  output logic        done_o
);
  logic [63:0] x_q;
  logic [63:0] r_q;
  logic [63:0] bit_q;
  logic [63:0] rb;
  logic        busy_q;
  logic        done_q;

  assign rb = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      r_q   <= '0;
      bit_q <= {2'b01, 62'd0};
    end else if (busy_q) begin
      if (x_q >= rb) begin
        x_q <= x_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = r_q[31:0];
  assign done_o = done_q;
endmodule

// ===== rtl/lme_wmul.sv =====
// ----------------------------------------------------------------------------
// lme_wmul
// 64x64 unsigned multiplier built from four 32x32 partial products,
// one per cycle, added into a 128-bit sum in the following cycle.
// ----------------------------------------------------------------------------
module lme_wmul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lme_pkg::MulW-1:0]      a_i,
  input  logic [lme_pkg::MulW-1:0]      b_i,
  output logic [2*lme_pkg::MulW-1:0]    prod_o,
  output logic                          done_o
);
  import lme_pkg::*;

  localparam int unsigned HalfW = MulW / 2;

  logic [MulW-1:0]   a_q;
  logic [MulW-1:0]   b_q;
  logic [2:0]        step_q;
  logic              busy_q;
  logic              pp_v_q;
  logic              done_q;
  logic [MulW-1:0]   pp_q;
  logic [1:0]        sh_q;
  logic [2*MulW-1:0] acc_q;
  logic [HalfW-1:0]  a_half;
  logic [HalfW-1:0]  b_half;

  assign a_half = step_q[1] ? a_q[MulW-1:HalfW] : a_q[HalfW-1:0];
  assign b_half = step_q[0] ? b_q[MulW-1:HalfW] : b_q[HalfW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pp_v_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        pp_v_q <= 1'b0;
        step_q <= '0;
      end else if (busy_q) begin
        pp_v_q <= !step_q[2];
        if (!step_q[2]) begin
          step_q <= step_q + 3'd1;
        end else if (pp_v_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (!step_q[2]) begin
        pp_q <= a_half * b_half;
        sh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
      end
      if (pp_v_q) begin
        acc_q <= acc_q + ({{MulW{1'b0}}, pp_q} << {sh_q, 5'd0});
      end
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;
endmodule

// ===== rtl/linear_model_error_metrics_core.sv =====
// ----------------------------------------------------------------------------
// linear_model_error_metrics_core
// Linear price prediction with running error metrics over a test set.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*   : write the eight Q16.16 coefficients while the block is idle.
//   in_i    : one sample per request (features, actual price, last flag).
//   out_o   : one result per sample: the prediction, plus the set metrics
//             when the sample closes the set.
// Throughput: one sample at a time. A sample's run from accept to result
// is set by the 56 one-bit steps of the shared divider for the percentage
// error, which is skipped when the price is zero or the set is full. A
// closing sample adds the mean divisions, the square root, the three
// hit-rate divisions, the three 64x64 products and, when the prices vary,
// the 94-step R-squared division.
// The next sample is accepted as soon as a result sits in the output
// register; when the receiver stalls, the following result waits until the
// output register empties.
// Reset clears the coefficients, the accumulators and the output valid flag.
// ----------------------------------------------------------------------------
module linear_model_error_metrics_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lme_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lme_pkg::CoefW-1:0]      cfg_data_i,
  lme_stream_if.sink                     in_i,
  lme_stream_if.source                   out_o
);
  import lme_pkg::*;

  localparam logic [63:0] SatMax48 = 64'(48'hFFFF_FFFF_FFFF);
  localparam logic [63:0] SatMax64 = '1;
  localparam logic [63:0] SatMax16 = 64'(16'hFFFF);

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] max);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, max}) ? max : s[63:0];
  endfunction

  st_e state_q, state_d;
  logic pend_q, pend_d;

  logic signed [CoefW-1:0] coef_q [NumLanes];
  logic        [OpndW-1:0] opnd   [NumLanes];
  logic signed [ProdW-1:0] prod   [NumLanes];
  logic signed [PredW-1:0] pred_w;

  logic        in_fire;
  logic        in_ready;
  logic        merge_en;
  logic        acc_en;
  logic        price_nz;

  logic [23:0] price_q;
  logic        last_q;
  logic [40:0] ae_q;
  logic [40:0] ae_w;
  logic signed [40:0] e_w;
  logic [63:0] sq_q;
  logic [47:0] psq_q;
  logic [2:0]  hit_q;
  logic [31:0] pct_q;
  logic [55:0] pct_num_w;

  logic [15:0] cnt_q;
  logic [47:0] abs_sum_q;
  logic [63:0] sq_sum_q;
  logic [47:0] pct_sum_q;
  logic [47:0] psum_q;
  logic [63:0] psq_sum_q;
  logic [15:0] hits_low_q, hits_mid_q, hits_high_q;

  logic [31:0]  mae_q;
  logic [63:0]  msq_q;
  logic [31:0]  rmse_q;
  logic [15:0]  mape_q;
  logic [14:0]  hpl_q, hpm_q, hph_q;
  logic [15:0]  r2_q;
  logic [127:0] wa_q, wb_q, wc_q;

  logic               div_go, sqrt_go, mul_go;
  logic               div_start, sqrt_start, mul_start;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic [DivCntW-1:0] div_iters;
  logic [DivNumW-1:0] div_quo;
  logic               div_done;
  logic [31:0]        sqrt_root;
  logic               sqrt_done;
  logic [MulW-1:0]    mul_a, mul_b;
  logic [2*MulW-1:0]  mul_prod;
  logic               mul_done;
  logic               unit_done;
  logic               unit_fin;
  logic [15:0]        hit_src;
  logic               out_load;
  logic               out_valid_q;
  out_item_t          out_q;
  out_item_t          out_d;

  assign in_fire  = in_i.valid && in_ready;
  assign in_i.ready = in_ready;
  assign acc_en   = cnt_q < MaxSamples;
  assign price_nz = price_q != '0;

  // lane operands, all on the Q.8 grid of the house size
  always_comb begin
    opnd[RegIntercept] = OpndW'(256);
    opnd[RegSize]      = in_i.payload.house_size;
    opnd[RegLocation]  = {8'd0, in_i.payload.location_code, 8'd0};
    opnd[RegSecurity]  = {8'd0, in_i.payload.security_level, 8'd0};
    opnd[RegGarage]    = {8'd0, in_i.payload.garage_count, 8'd0};
    opnd[RegFloor]     = {8'd0, in_i.payload.floor_index, 8'd0};
    opnd[RegRooms]     = {8'd0, in_i.payload.room_count, 8'd0};
    opnd[RegYear]      = {4'd0, in_i.payload.built_year, 8'd0};
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    lme_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (in_fire),
      .coef_i (coef_q[g]),
      .opnd_i (opnd[g]),
      .prod_o (prod[g])
    );
  end

  lme_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (merge_en),
    .prod_i (prod),
    .pred_o (pred_w)
  );

  lme_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  lme_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (msq_q),
    .root_o  (sqrt_root),
    .done_o  (sqrt_done)
  );

  lme_wmul u_wmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  assign e_w       = {pred_w[PredW-1], pred_w} - {17'd0, price_q};
  assign ae_w      = e_w[40] ? 41'(-e_w) : e_w;
  assign pct_num_w = 56'(ae_q) * 56'(PctScaleQ8);

  // FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    merge_en  = 1'b0;
    div_go    = 1'b0;
    sqrt_go   = 1'b0;
    mul_go    = 1'b0;
    div_num   = '0;
    div_den   = DivDenW'(cnt_q);
    div_iters = IterSum48;
    mul_a     = MulW'(cnt_q);
    mul_b     = sq_sum_q;
    unit_done = 1'b0;
    out_load  = 1'b0;
    hit_src   = hits_low_q;
    case (state_q)
      StIdle:  in_ready = 1'b1;
      StMerge: merge_en = 1'b1;
      StPct: begin
        div_go    = 1'b1;
        div_num   = {pct_num_w, 40'd0};
        div_den   = DivDenW'(price_q);
        div_iters = IterPct;
        unit_done = div_done;
      end
      StMae: begin
        div_go    = 1'b1;
        div_num   = {abs_sum_q, 48'd0};
        unit_done = div_done;
      end
      StMse: begin
        div_go    = 1'b1;
        div_num   = {sq_sum_q, 32'd0};
        div_iters = IterSum64;
        unit_done = div_done;
      end
      StRoot: begin
        sqrt_go   = 1'b1;
        unit_done = sqrt_done;
      end
      StMape: begin
        div_go    = 1'b1;
        div_num   = {pct_sum_q, 48'd0};
        unit_done = div_done;
      end
      StHitL, StHitM, StHitH: begin
        if (state_q == StHitM) begin
          hit_src = hits_mid_q;
        end else if (state_q == StHitH) begin
          hit_src = hits_high_q;
        end
        div_go    = 1'b1;
        div_num   = {31'(hit_src) * 31'(PctScaleQ8), 65'd0};
        div_iters = IterHit;
        unit_done = div_done;
      end
      StMulA: begin
        mul_go    = 1'b1;
        mul_b     = psq_sum_q;
        unit_done = mul_done;
      end
      StMulB: begin
        mul_go    = 1'b1;
        mul_a     = MulW'(psum_q);
        mul_b     = MulW'(psum_q);
        unit_done = mul_done;
      end
      StMulC: begin
        mul_go    = 1'b1;
        unit_done = mul_done;
      end
      StR2Div: begin
        div_go    = 1'b1;
        div_num   = {wc_q[79:0], 16'd0};
        div_den   = wa_q - wb_q;
        div_iters = IterR2;
        unit_done = div_done;
      end
      StOut:   out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
    div_start  = div_go && !pend_q;
    sqrt_start = sqrt_go && !pend_q;
    mul_start  = mul_go && !pend_q;
    unit_fin   = pend_q && unit_done;
    pend_d     = (div_go || sqrt_go || mul_go) && !unit_fin;
  end

  // FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_fire) state_d = StMerge;
      StMerge: state_d = StErr;
      StErr:   state_d = StTerm;
      StTerm: begin
        if (!acc_en) begin
          state_d = last_q ? StMae : StOut;
        end else begin
          state_d = price_nz ? StPct : StAcc;
        end
      end
      StPct:   if (unit_fin) state_d = StAcc;
      StAcc:   state_d = last_q ? StMae : StOut;
      StMae:   if (unit_fin) state_d = StMse;
      StMse:   if (unit_fin) state_d = StRoot;
      StRoot:  if (unit_fin) state_d = StMape;
      StMape:  if (unit_fin) state_d = StHitL;
      StHitL:  if (unit_fin) state_d = StHitM;
      StHitM:  if (unit_fin) state_d = StHitH;
      StHitH:  if (unit_fin) state_d = StMulA;
      StMulA:  if (unit_fin) state_d = StMulB;
      StMulB:  if (unit_fin) state_d = StMulC;
      StMulC: begin
        // no spread in the prices: R-squared stays 0
        if (unit_fin) state_d = (wb_q >= wa_q) ? StOut : StR2Div;
      end
      StR2Div: if (unit_fin) state_d = StOut;
      StOut:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_d.predicted_price    = pred_w;
    out_d.metrics_valid      = last_q;
    out_d.samples_seen       = last_q ? cnt_q : '0;
    out_d.mean_abs_error     = last_q ? mae_q : '0;
    out_d.root_mean_sq_error = last_q ? rmse_q : '0;
    out_d.mean_abs_pct_error = last_q ? mape_q : '0;
    out_d.r_squared          = last_q ? r2_q : '0;
    out_d.hit_pct_low        = last_q ? hpl_q : '0;
    out_d.hit_pct_mid        = last_q ? hpm_q : '0;
    out_d.hit_pct_high       = last_q ? hph_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NumLanes; k++) begin
        coef_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        coef_q[cfg_idx_i] <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      abs_sum_q   <= '0;
      sq_sum_q    <= '0;
      pct_sum_q   <= '0;
      psum_q      <= '0;
      psq_sum_q   <= '0;
      hits_low_q  <= '0;
      hits_mid_q  <= '0;
      hits_high_q <= '0;
    end else if (state_q == StAcc) begin
      cnt_q     <= cnt_q + 16'd1;
      abs_sum_q <= 48'(sat_add(64'(abs_sum_q), 64'(ae_q), SatMax48));
      sq_sum_q  <= sat_add(sq_sum_q, sq_q, SatMax64);
      pct_sum_q <= 48'(sat_add(64'(pct_sum_q), 64'(pct_q), SatMax48));
      psum_q    <= 48'(sat_add(64'(psum_q), 64'(price_q), SatMax48));
      psq_sum_q <= sat_add(psq_sum_q, 64'(psq_q), SatMax64);
      if (hit_q[0]) hits_low_q  <= 16'(sat_add(64'(hits_low_q), 64'd1, SatMax16));
      if (hit_q[1]) hits_mid_q  <= 16'(sat_add(64'(hits_mid_q), 64'd1, SatMax16));
      if (hit_q[2]) hits_high_q <= 16'(sat_add(64'(hits_high_q), 64'd1, SatMax16));
    end else if (out_load && last_q) begin
      // drop the finished set
      cnt_q       <= '0;
      abs_sum_q   <= '0;
      sq_sum_q    <= '0;
      pct_sum_q   <= '0;
      psum_q      <= '0;
      psq_sum_q   <= '0;
      hits_low_q  <= '0;
      hits_mid_q  <= '0;
      hits_high_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      price_q <= in_i.payload.actual_price;
      last_q  <= in_i.payload.last_sample;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    case (state_q)
      StErr: ae_q <= ae_w;
      StTerm: begin
        sq_q     <= (ae_q[40:32] != '0) ? SatMax64 : ae_q[31:0] * ae_q[31:0];
        psq_q    <= price_q * price_q;
        pct_q    <= '1;
        hit_q[0] <= price_nz && ((48'(ae_q) * 48'(PctScale)) <= 48'(HitLimitLow) * 48'(price_q));
        hit_q[1] <= price_nz && ((48'(ae_q) * 48'(PctScale)) <= 48'(HitLimitMid) * 48'(price_q));
        hit_q[2] <= price_nz && ((48'(ae_q) * 48'(PctScale)) <= 48'(HitLimitHigh) * 48'(price_q));
      end
      StPct:  if (unit_fin) pct_q <= (div_quo[95:32] != '0) ? '1 : div_quo[31:0];
      StMae:  if (unit_fin) mae_q <= (div_quo[95:32] != '0) ? '1 : div_quo[31:0];
      StMse:  if (unit_fin) msq_q <= div_quo[63:0];
      StRoot: if (unit_fin) rmse_q <= sqrt_root;
      StMape: if (unit_fin) mape_q <= (div_quo[95:16] != '0) ? '1 : div_quo[15:0];
      StHitL: if (unit_fin) hpl_q <= div_quo[14:0];
      StHitM: if (unit_fin) hpm_q <= div_quo[14:0];
      StHitH: if (unit_fin) hph_q <= div_quo[14:0];
      StMulA: if (unit_fin) wa_q <= mul_prod;
      StMulB: if (unit_fin) wb_q <= mul_prod;
      StMulC: begin
        if (unit_fin) begin
          wc_q <= mul_prod;
          r2_q <= '0;
        end
      end
      StR2Div: begin
        if (unit_fin) begin
          r2_q <= (div_quo > DivNumW'(R2Limit)) ? R2Min : R2One - div_quo[15:0];
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
endmodule

// ===== rtl/lme_checker.sv =====
// ----------------------------------------------------------------------------
// lme_checker
// Port-level checks of the linear model error metrics block.
// ----------------------------------------------------------------------------
module lme_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  lme_pkg::out_item_t out_item_i
);
  import lme_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result changed");

  // one sample at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while a sample is in flight");

  a_plain_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.metrics_valid |->
      out_item_i.samples_seen == '0 && out_item_i.mean_abs_error == '0 &&
      out_item_i.root_mean_sq_error == '0 && out_item_i.mean_abs_pct_error == '0 &&
      out_item_i.r_squared == '0 && out_item_i.hit_pct_low == '0 &&
      out_item_i.hit_pct_mid == '0 && out_item_i.hit_pct_high == '0)
    else $error("metric fields set on a plain result");

  a_set_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.metrics_valid |->
      out_item_i.samples_seen != '0 && out_item_i.hit_pct_low <= PctScaleQ8 &&
      out_item_i.hit_pct_mid <= PctScaleQ8 && out_item_i.hit_pct_high <= PctScaleQ8)
    else $error("set result out of range");
endmodule

bind linear_model_error_metrics_core lme_checker u_lme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);
